// File: hdl/segment_intersection_3d_top_macros.svh
// Assertion macros used by the segment intersection top level
`ifndef SEGMENT_INTERSECTION_3D_TOP_MACROS_SVH
`define SEGMENT_INTERSECTION_3D_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define SI3D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SI3D_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define SI3D_ASSERT(lbl, prop, msg)
`define SI3D_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: hdl/si3d_pkg.sv
// Package: widths, status codes and payload types of the segment intersection block
`timescale 1ns / 1ps
package si3d_pkg;
  localparam int CW = 16;
  localparam int FW = 16;
  localparam int DW = CW + 1;
  localparam int NW = 2 * DW + 1;
  localparam int LB = (NW + 1) / 2;
  localparam int PPW = 2 * (LB + 1);
  localparam int TW = DW + NW + 2;
  localparam int PW = 2 * NW + 2;
  localparam int CH = (PW + 2) / 3;
  localparam int MW = CW + 3 * CH;
  localparam int XW = MW + FW;
  localparam int QB = CW + FW;
  localparam int HW = CW + FW;
  localparam int SW = 2;
  localparam int OW = FW + 1;

  localparam logic [SW-1:0] ST_HIT  = 2'd0;
  localparam logic [SW-1:0] ST_SKEW = 2'd1;
  localparam logic [SW-1:0] ST_PARA = 2'd2;
  localparam logic [SW-1:0] ST_OUT  = 2'd3;

  localparam logic [OW-1:0] POS_ONE = OW'(1) << FW;

  typedef struct packed {
    logic [3:0][PW-1:0] rem;
    logic [3:0][QB-1:0] wrd;
    logic [PW-1:0]      den;
    logic [2:0]         neg;
    logic [2:0][HW-1:0] base;
    logic [SW-1:0]      status;
  } div_t;

  typedef struct packed {
    logic [SW-1:0]      status;
    logic [2:0][HW-1:0] hit;
    logic [OW-1:0]      pos;
  } res_t;
endpackage

// File: hdl/segment_intersection_3d_top.sv
// Top level: intersection of two 3D integer segments, fully pipelined
//
// Input channel: twelve signed 16-bit endpoint coordinates, handshake
// in_valid_i / in_ready_o. Output channel: status, hit point x/y/z in
// Q16.16 and position s in Q1.16, handshake out_valid_o / out_ready_i.
// Status 0 hit, 1 not coplanar, 2 parallel or degenerate, 3 outside the
// first segment; every other field is zero unless status is 0.
// One beat is accepted per cycle while in_ready_o is high. The pipeline has 7
// front stages (differences, cross products, split dot products, sums, status
// and scaling), 32 divider cells that each resolve one quotient bit of all
// four lanes, and one result stage.
// On reset all valid bits clear and no output beat is pending.
// When the receiver stalls, the pending result moves into a skid register;
// while that register is full the pipeline holds and in_ready_o is low,
// and it drains as soon as out_ready_i returns.
`timescale 1ns / 1ps
`include "segment_intersection_3d_top_macros.svh"
module segment_intersection_3d_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [si3d_pkg::CW-1:0]   a_start_x_i,
  input  logic [si3d_pkg::CW-1:0]   a_start_y_i,
  input  logic [si3d_pkg::CW-1:0]   a_start_z_i,
  input  logic [si3d_pkg::CW-1:0]   a_end_x_i,
  input  logic [si3d_pkg::CW-1:0]   a_end_y_i,
  input  logic [si3d_pkg::CW-1:0]   a_end_z_i,
  input  logic [si3d_pkg::CW-1:0]   b_start_x_i,
  input  logic [si3d_pkg::CW-1:0]   b_start_y_i,
  input  logic [si3d_pkg::CW-1:0]   b_start_z_i,
  input  logic [si3d_pkg::CW-1:0]   b_end_x_i,
  input  logic [si3d_pkg::CW-1:0]   b_end_y_i,
  input  logic [si3d_pkg::CW-1:0]   b_end_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [si3d_pkg::SW-1:0]   status_o,
  output logic [si3d_pkg::HW-1:0]   hit_x_o,
  output logic [si3d_pkg::HW-1:0]   hit_y_o,
  output logic [si3d_pkg::HW-1:0]   hit_z_o,
  output logic [si3d_pkg::OW-1:0]   position_o
);
  import si3d_pkg::*;

  logic [2:0][CW-1:0] a0;
  logic [2:0][CW-1:0] a1;
  logic [2:0][CW-1:0] b0;
  logic [2:0][CW-1:0] b1;
  logic               adv;
  logic [QB:0]        vchain;
  div_t               chain [QB+1];
  div_t               last;
  logic [QB:0]        mag   [3];
  logic [QB:0]        off   [3];
  res_t               res_d;
  res_t               res_q;
  res_t               skid_q;
  res_t               shown;
  logic               res_v_q;
  logic               skid_v_q;
  logic               miss_beat;
  logic               hit_beat;
  logic               fields_zero;

  assign a0 = {a_start_z_i, a_start_y_i, a_start_x_i};
  assign a1 = {a_end_z_i, a_end_y_i, a_end_x_i};
  assign b0 = {b_start_z_i, b_start_y_i, b_start_x_i};
  assign b1 = {b_end_z_i, b_end_y_i, b_end_x_i};

  assign adv        = ~skid_v_q;
  assign in_ready_o = adv;

  si3d_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .a0_i    (a0),
    .a1_i    (a1),
    .b0_i    (b0),
    .b1_i    (b1),
    .valid_o (vchain[0]),
    .data_o  (chain[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_cell
    si3d_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (vchain[g]),
      .data_i  (chain[g]),
      .valid_o (vchain[g+1]),
      .data_o  (chain[g+1])
    );
  end

  assign last = chain[QB];

  always_comb begin
    res_d.status = last.status;
    for (int i = 0; i < 3; i++) begin
      mag[i] = {1'b0, last.wrd[i]} + (QB + 1)'(|last.rem[i]);
      off[i] = last.neg[i] ? -mag[i] : mag[i];
      res_d.hit[i] = (last.status == ST_HIT) ? last.base[i] + off[i][HW-1:0] : '0;
    end
    res_d.pos = (last.status == ST_HIT) ? last.wrd[3][OW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (adv) begin
        res_v_q <= vchain[QB];
      end
      if (adv && res_v_q && !out_ready_i) begin
        skid_v_q <= 1'b1;
      end else if (skid_v_q && out_ready_i) begin
        skid_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
    if (adv && res_v_q && !out_ready_i) begin
      skid_q <= res_q;
    end
  end

  assign shown       = skid_v_q ? skid_q : res_q;
  assign out_valid_o = skid_v_q | res_v_q;
  assign status_o    = shown.status;
  assign hit_x_o     = shown.hit[0];
  assign hit_y_o     = shown.hit[1];
  assign hit_z_o     = shown.hit[2];
  assign position_o  = shown.pos;

  assign miss_beat   = out_valid_o && (status_o != ST_HIT);
  assign hit_beat    = out_valid_o && (status_o == ST_HIT);
  assign fields_zero = (hit_x_o == '0) && (hit_y_o == '0) && (hit_z_o == '0)
                       && (position_o == '0);

  `SI3D_ASSERT_NEXT(a_skid_hold, skid_v_q && !out_ready_i, skid_v_q && $stable(skid_q), "skid lost")
  `SI3D_ASSERT_NEXT(a_stall_hold, !adv, $stable(res_v_q) && $stable(res_q), "result moved")
  `SI3D_ASSERT(a_miss_zero, miss_beat |-> fields_zero, "miss beat carries nonzero fields")
  `SI3D_ASSERT(a_pos_range, hit_beat |-> (position_o <= POS_ONE), "position above one")
endmodule

// File: hdl/si3d_front.sv
// Front pipeline: differences, cross products, dot products, status and divider setup
`timescale 1ns / 1ps
module si3d_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [2:0][si3d_pkg::CW-1:0]  a0_i,
  input  logic [2:0][si3d_pkg::CW-1:0]  a1_i,
  input  logic [2:0][si3d_pkg::CW-1:0]  b0_i,
  input  logic [2:0][si3d_pkg::CW-1:0]  b1_i,
  output logic                          valid_o,
  output si3d_pkg::div_t                data_o
);
  import si3d_pkg::*;

  function automatic logic signed [NW-1:0] cross_f(input logic signed [DW-1:0] p,
                                                   input logic signed [DW-1:0] q,
                                                   input logic signed [DW-1:0] r,
                                                   input logic signed [DW-1:0] s);
    return NW'(p) * NW'(s) - NW'(q) * NW'(r);
  endfunction

  logic [6:0] v_q;

  logic signed [DW-1:0] da1_q [3];
  logic signed [DW-1:0] db1_q [3];
  logic signed [DW-1:0] dc1_q [3];
  logic [HW-1:0]        bs1_q [3];

  logic signed [NW-1:0] n2_q  [3];
  logic signed [NW-1:0] e2_q  [3];
  logic signed [DW-1:0] dc2_q [3];
  logic [CW-1:0]        km2_q [3];
  logic [2:0]           kn2_q;
  logic [HW-1:0]        bs2_q [3];

  logic signed [PPW-1:0] tpa3_q [3];
  logic signed [PPW-1:0] tpb3_q [3];
  logic signed [PPW-1:0] npa3_q [3];
  logic signed [PPW-1:0] npb3_q [3];
  logic signed [PPW-1:0] npc3_q [3];
  logic signed [PPW-1:0] npd3_q [3];
  logic signed [PPW-1:0] dpa3_q [3];
  logic signed [PPW-1:0] dpb3_q [3];
  logic signed [PPW-1:0] dpc3_q [3];
  logic [CW-1:0]         km3_q  [3];
  logic [2:0]            kn3_q;
  logic [HW-1:0]         bs3_q  [3];

  logic signed [TW-1:0] tr4_q [3];
  logic signed [PW-1:0] nm4_q [3];
  logic signed [PW-1:0] dn4_q [3];
  logic [CW-1:0]        km4_q [3];
  logic [2:0]           kn4_q;
  logic [HW-1:0]        bs4_q [3];

  logic signed [TW-1:0] tr5_q;
  logic signed [PW-1:0] nm5_q;
  logic signed [PW-1:0] dn5_q;
  logic [CW-1:0]        km5_q [3];
  logic [2:0]           kn5_q;
  logic [HW-1:0]        bs5_q [3];

  logic [2:0][2:0][CW+CH-1:0] mp6_q;
  logic [3*CH-1:0]            nm6_q;
  logic [PW-1:0]              dn6_q;
  logic [SW-1:0]              st6_q;
  logic [2:0]                 kn6_q;
  logic [HW-1:0]              bs6_q [3];

  logic [3*CH-1:0] nm_pad;
  logic [SW-1:0]   st_d;
  logic [MW-1:0]   m_lane [4];
  logic [XW-1:0]   x_lane [4];
  div_t            out_d;
  div_t            out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        da1_q[i] <= DW'($signed(a1_i[i])) - DW'($signed(a0_i[i]));
        db1_q[i] <= DW'($signed(b1_i[i])) - DW'($signed(b0_i[i]));
        dc1_q[i] <= DW'($signed(b0_i[i])) - DW'($signed(a0_i[i]));
        bs1_q[i] <= {a0_i[i], {FW{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      n2_q[0] <= cross_f(da1_q[1], da1_q[2], db1_q[1], db1_q[2]);
      n2_q[1] <= cross_f(da1_q[2], da1_q[0], db1_q[2], db1_q[0]);
      n2_q[2] <= cross_f(da1_q[0], da1_q[1], db1_q[0], db1_q[1]);
      e2_q[0] <= cross_f(dc1_q[1], dc1_q[2], db1_q[1], db1_q[2]);
      e2_q[1] <= cross_f(dc1_q[2], dc1_q[0], db1_q[2], db1_q[0]);
      e2_q[2] <= cross_f(dc1_q[0], dc1_q[1], db1_q[0], db1_q[1]);
      for (int i = 0; i < 3; i++) begin
        dc2_q[i] <= dc1_q[i];
        km2_q[i] <= da1_q[i][DW-1] ? CW'(-da1_q[i]) : CW'(da1_q[i]);
        kn2_q[i] <= da1_q[i][DW-1];
        bs2_q[i] <= bs1_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        tpa3_q[i] <= PPW'(dc2_q[i]) * PPW'($signed(n2_q[i][NW-1:LB]));
        tpb3_q[i] <= PPW'(dc2_q[i]) * PPW'($signed({1'b0, n2_q[i][LB-1:0]}));
        npa3_q[i] <= PPW'($signed(e2_q[i][NW-1:LB])) * PPW'($signed(n2_q[i][NW-1:LB]));
        npb3_q[i] <= PPW'($signed(e2_q[i][NW-1:LB]))
                     * PPW'($signed({1'b0, n2_q[i][LB-1:0]}));
        npc3_q[i] <= PPW'($signed({1'b0, e2_q[i][LB-1:0]}))
                     * PPW'($signed(n2_q[i][NW-1:LB]));
        npd3_q[i] <= PPW'($signed({1'b0, e2_q[i][LB-1:0]}))
                     * PPW'($signed({1'b0, n2_q[i][LB-1:0]}));
        dpa3_q[i] <= PPW'($signed(n2_q[i][NW-1:LB])) * PPW'($signed(n2_q[i][NW-1:LB]));
        dpb3_q[i] <= PPW'($signed(n2_q[i][NW-1:LB]))
                     * PPW'($signed({1'b0, n2_q[i][LB-1:0]}));
        dpc3_q[i] <= PPW'($signed({1'b0, n2_q[i][LB-1:0]}))
                     * PPW'($signed({1'b0, n2_q[i][LB-1:0]}));
        km3_q[i]  <= km2_q[i];
        kn3_q[i]  <= kn2_q[i];
        bs3_q[i]  <= bs2_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        tr4_q[i] <= (TW'(tpa3_q[i]) <<< LB) + TW'(tpb3_q[i]);
        nm4_q[i] <= (PW'(npa3_q[i]) <<< (2 * LB))
                    + ((PW'(npb3_q[i]) + PW'(npc3_q[i])) <<< LB) + PW'(npd3_q[i]);
        dn4_q[i] <= (PW'(dpa3_q[i]) <<< (2 * LB)) + (PW'(dpb3_q[i]) <<< (LB + 1))
                    + PW'(dpc3_q[i]);
        km4_q[i] <= km3_q[i];
        kn4_q[i] <= kn3_q[i];
        bs4_q[i] <= bs3_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tr5_q <= tr4_q[0] + tr4_q[1] + tr4_q[2];
      nm5_q <= nm4_q[0] + nm4_q[1] + nm4_q[2];
      dn5_q <= dn4_q[0] + dn4_q[1] + dn4_q[2];
      for (int i = 0; i < 3; i++) begin
        km5_q[i] <= km4_q[i];
        kn5_q[i] <= kn4_q[i];
        bs5_q[i] <= bs4_q[i];
      end
    end
  end

  always_comb begin
    nm_pad = (3 * CH)'(nm5_q[PW-1:0]);
    if (tr5_q != '0) begin
      st_d = ST_SKEW;
    end else if (dn5_q == '0) begin
      st_d = ST_PARA;
    end else if (nm5_q[PW-1] || (nm5_q > dn5_q)) begin
      st_d = ST_OUT;
    end else begin
      st_d = ST_HIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mp6_q[i][j] <= (CW + CH)'(km5_q[i]) * (CW + CH)'(nm_pad[j*CH +: CH]);
        end
        bs6_q[i] <= bs5_q[i];
      end
      nm6_q <= nm_pad;
      dn6_q <= dn5_q[PW-1:0];
      st6_q <= st_d;
      kn6_q <= kn5_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_lane[i] = MW'(mp6_q[i][0]) + (MW'(mp6_q[i][1]) << CH)
                  + (MW'(mp6_q[i][2]) << (2 * CH));
    end
    m_lane[3] = MW'(nm6_q);
    for (int i = 0; i < 4; i++) begin
      x_lane[i] = {m_lane[i], {FW{1'b0}}};
      out_d.rem[i] = PW'(x_lane[i] >> QB);
      out_d.wrd[i] = x_lane[i][QB-1:0];
    end
    out_d.den = dn6_q;
    out_d.neg = kn6_q;
    for (int i = 0; i < 3; i++) begin
      out_d.base[i] = bs6_q[i];
    end
    out_d.status = st6_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = v_q[6];
  assign data_o  = out_q;
endmodule

// File: hdl/si3d_div_cell.sv
// Divider cell: one restoring quotient bit for each of the four lanes
`timescale 1ns / 1ps
module si3d_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  si3d_pkg::div_t data_i,
  output logic           valid_o,
  output si3d_pkg::div_t data_o
);
  import si3d_pkg::*;

  logic [PW:0]   trial [4];
  logic [PW+1:0] diff  [4];
  div_t          cell_d;
  div_t          cell_q;
  logic          valid_q;

  always_comb begin
    cell_d = data_i;
    for (int i = 0; i < 4; i++) begin
      trial[i] = {data_i.rem[i], data_i.wrd[i][QB-1]};
      diff[i]  = {1'b0, trial[i]} - {2'b0, data_i.den};
      cell_d.rem[i] = diff[i][PW+1] ? trial[i][PW-1:0] : diff[i][PW-1:0];
      cell_d.wrd[i] = {data_i.wrd[i][QB-2:0], ~diff[i][PW+1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = cell_q;
endmodule
